@@ rtl/mcc_pkg.sv @@
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types, character codes and the letter code table of the Morse codec.
// ----------------------------------------------------------------------------
package mcc_pkg;

    localparam int CHAR_W      = 8;
    localparam int NUM_LETTERS = 26;
    localparam int MAX_MARKS   = 4;
    localparam int MAX_RUN     = MAX_MARKS + 1;
    localparam int COUNT_W     = $clog2(MAX_RUN + 1);
    localparam int LEN_W       = $clog2(MAX_MARKS + 1);
    localparam int IDX_W       = $clog2(NUM_LETTERS);

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'h00;

    // One letter code: mark count and dash flags, bit i is mark i
    typedef struct packed {
        logic [LEN_W-1:0]     len;
        logic [MAX_MARKS-1:0] bits;
    } mcc_code_t;

    // One run of output characters, first character in slot 0
    typedef struct packed {
        logic [COUNT_W-1:0]                count;
        logic [MAX_RUN-1:0][CHAR_W-1:0]    chars;
    } mcc_run_t;

    // Letter code table, A at index 0
    function automatic mcc_code_t morse_entry(input logic [IDX_W-1:0] idx);
        mcc_code_t c;
        case (idx)
            5'd0:    c = '{len: 3'd2, bits: 4'b0010};
            5'd1:    c = '{len: 3'd4, bits: 4'b0001};
            5'd2:    c = '{len: 3'd4, bits: 4'b0101};
            5'd3:    c = '{len: 3'd3, bits: 4'b0001};
            5'd4:    c = '{len: 3'd1, bits: 4'b0000};
            5'd5:    c = '{len: 3'd4, bits: 4'b0100};
            5'd6:    c = '{len: 3'd3, bits: 4'b0011};
            5'd7:    c = '{len: 3'd4, bits: 4'b0000};
            5'd8:    c = '{len: 3'd2, bits: 4'b0000};
            5'd9:    c = '{len: 3'd4, bits: 4'b1110};
            5'd10:   c = '{len: 3'd3, bits: 4'b0101};
            5'd11:   c = '{len: 3'd4, bits: 4'b0010};
            5'd12:   c = '{len: 3'd2, bits: 4'b0011};
            5'd13:   c = '{len: 3'd2, bits: 4'b0001};
            5'd14:   c = '{len: 3'd3, bits: 4'b0111};
            5'd15:   c = '{len: 3'd4, bits: 4'b0110};
            5'd16:   c = '{len: 3'd4, bits: 4'b1011};
            5'd17:   c = '{len: 3'd3, bits: 4'b0010};
            5'd18:   c = '{len: 3'd3, bits: 4'b0000};
            5'd19:   c = '{len: 3'd1, bits: 4'b0001};
            5'd20:   c = '{len: 3'd3, bits: 4'b0100};
            5'd21:   c = '{len: 3'd4, bits: 4'b1000};
            5'd22:   c = '{len: 3'd3, bits: 4'b0110};
            5'd23:   c = '{len: 3'd4, bits: 4'b1001};
            5'd24:   c = '{len: 3'd4, bits: 4'b1101};
            5'd25:   c = '{len: 3'd4, bits: 4'b0011};
            default: c = '{len: 3'd0, bits: 4'b0000};
        endcase
        return c;
    endfunction

    // Look up a mark buffer; returns the uppercase letter, or CHAR_NONE
    function automatic logic [CHAR_W-1:0] morse_lookup(
        input logic [LEN_W-1:0]     len,
        input logic [MAX_MARKS-1:0] bits
    );
        logic [CHAR_W-1:0] letter;
        mcc_code_t         c;
        letter = CHAR_NONE;
        for (int i = NUM_LETTERS - 1; i >= 0; i--)
        begin
            c = morse_entry(IDX_W'(i));
            if (c.len == len && c.bits == bits)
            begin
                letter = CHAR_UPPER_A + CHAR_W'(i);
            end
        end
        return letter;
    endfunction

endpackage

@@ rtl/mcc_if.sv @@
// ----------------------------------------------------------------------------
// mcc_in_if / mcc_out_if
// Valid/ready channels for input characters and output characters.
// ----------------------------------------------------------------------------
interface mcc_in_if;
    logic                       valid;
    logic                       ready;
    logic [mcc_pkg::CHAR_W-1:0] in_char;
    logic                       end_of_message;

    modport source (output valid, output in_char, output end_of_message, input ready);
    modport sink   (input valid, input in_char, input end_of_message, output ready);
endinterface

interface mcc_out_if;
    logic                       valid;
    logic                       ready;
    logic [mcc_pkg::CHAR_W-1:0] out_char;
    logic                       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

@@ rtl/mcc_core.sv @@
// ----------------------------------------------------------------------------
// mcc_core
// Per-character encode/decode logic: builds the output run of one input beat
// and keeps the decode mark buffer and the mode register.
// ----------------------------------------------------------------------------
module mcc_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic                       accept,
    input  logic [mcc_pkg::CHAR_W-1:0] in_char,
    input  logic                       end_of_message,
    output mcc_pkg::mcc_run_t          run
);

    logic                          decode_mode_reg;
    logic [mcc_pkg::LEN_W-1:0]     mark_count_reg, mark_count_next;
    logic [mcc_pkg::MAX_MARKS-1:0] mark_bits_reg, mark_bits_next;
    logic                          bad_code_reg, bad_code_next;

    logic                          is_upper, is_lower, is_space, is_dot, is_dash;
    logic [mcc_pkg::CHAR_W-1:0]    letter_off;
    mcc_pkg::mcc_code_t            code;
    mcc_pkg::mcc_run_t             enc_run, dec_run;
    logic [mcc_pkg::LEN_W-1:0]     mid_count;
    logic [mcc_pkg::MAX_MARKS-1:0] mid_bits;
    logic                          mid_bad;
    logic [mcc_pkg::CHAR_W-1:0]    letter_space, letter_eom, letter;

    // Classify the input character
    always_comb
    begin
        is_upper = (in_char >= mcc_pkg::CHAR_UPPER_A) && (in_char <= mcc_pkg::CHAR_UPPER_Z);
        is_lower = (in_char >= mcc_pkg::CHAR_LOWER_A) && (in_char <= mcc_pkg::CHAR_LOWER_Z);
        is_space = (in_char == mcc_pkg::CHAR_SPACE);
        is_dot   = (in_char == mcc_pkg::CHAR_DOT);
        is_dash  = (in_char == mcc_pkg::CHAR_DASH);
        letter_off = is_lower ? (in_char - mcc_pkg::CHAR_LOWER_A)
                              : (in_char - mcc_pkg::CHAR_UPPER_A);
        code = mcc_pkg::morse_entry(letter_off[mcc_pkg::IDX_W-1:0]);
    end

    // Encode run: a space and the letter's marks, or two spaces for a space
    always_comb
    begin
        enc_run       = '0;
        enc_run.chars[0] = mcc_pkg::CHAR_SPACE;
        for (int i = 0; i < mcc_pkg::MAX_MARKS; i++)
        begin
            enc_run.chars[i+1] = code.bits[i] ? mcc_pkg::CHAR_DASH : mcc_pkg::CHAR_DOT;
        end
        if (is_upper || is_lower)
        begin
            enc_run.count = mcc_pkg::COUNT_W'(code.len) + mcc_pkg::COUNT_W'(1);
        end
        else if (is_space)
        begin
            enc_run.chars[1] = mcc_pkg::CHAR_SPACE;
            enc_run.count    = mcc_pkg::COUNT_W'(2);
        end
    end

    // Decode: flush on space, else gather a mark or flag a bad code
    always_comb
    begin
        letter_space = (!bad_code_reg && mark_count_reg != '0)
                     ? mcc_pkg::morse_lookup(mark_count_reg, mark_bits_reg)
                     : mcc_pkg::CHAR_NONE;
        mid_count = mark_count_reg;
        mid_bits  = mark_bits_reg;
        mid_bad   = bad_code_reg;
        if (is_space)
        begin
            mid_count = '0;
            mid_bits  = '0;
            mid_bad   = 1'b0;
        end
        else if (is_dot || is_dash)
        begin
            if (mark_count_reg < mcc_pkg::LEN_W'(mcc_pkg::MAX_MARKS))
            begin
                if (is_dash)
                begin
                    mid_bits[mark_count_reg[mcc_pkg::LEN_W-2:0]] = 1'b1;
                end
                mid_count = mark_count_reg + mcc_pkg::LEN_W'(1);
            end
            else
            begin
                mid_bad = 1'b1;
            end
        end
        else
        begin
            mid_bad = 1'b1;
        end

        // End of message flushes what is left after this character
        letter_eom = (!mid_bad && mid_count != '0)
                   ? mcc_pkg::morse_lookup(mid_count, mid_bits)
                   : mcc_pkg::CHAR_NONE;
        mark_count_next = mid_count;
        mark_bits_next  = mid_bits;
        bad_code_next   = mid_bad;
        if (end_of_message)
        begin
            mark_count_next = '0;
            mark_bits_next  = '0;
            bad_code_next   = 1'b0;
        end

        letter = is_space ? letter_space
               : (end_of_message ? letter_eom : mcc_pkg::CHAR_NONE);
        dec_run          = '0;
        dec_run.chars[0] = letter;
        dec_run.count    = (letter != mcc_pkg::CHAR_NONE) ? mcc_pkg::COUNT_W'(1) : '0;
    end

    assign run = decode_mode_reg ? dec_run : enc_run;

    // Hold the mode register and the decode buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= 1'b0;
            mark_count_reg  <= '0;
            mark_bits_reg   <= '0;
            bad_code_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                decode_mode_reg <= cfg_wdata;
            end
            if (accept && decode_mode_reg)
            begin
                mark_count_reg <= mark_count_next;
                mark_bits_reg  <= mark_bits_next;
                bad_code_reg   <= bad_code_next;
            end
        end
    end

endmodule

@@ rtl/mcc_serializer.sv @@
// ----------------------------------------------------------------------------
// mcc_serializer
// Run register: holds one run of output characters and shifts it out one beat
// per cycle while out_ch.ready is high, taking the next run as its last beat leaves.
// ----------------------------------------------------------------------------
module mcc_serializer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  mcc_pkg::mcc_run_t  run,
    output logic               free,
    mcc_out_if.source          out_ch
);

    logic [mcc_pkg::COUNT_W-1:0]                    count_reg;
    logic [mcc_pkg::MAX_RUN-1:0][mcc_pkg::CHAR_W-1:0] chars_reg;
    logic                                           take;

    assign out_ch.valid       = (count_reg != '0);
    assign out_ch.out_char    = chars_reg[0];
    assign out_ch.last_of_run = (count_reg == mcc_pkg::COUNT_W'(1));
    assign take               = out_ch.valid && out_ch.ready;

    // Free when empty or when the final beat leaves this cycle
    assign free = (count_reg == '0) || (out_ch.last_of_run && out_ch.ready);

    // Load a new run, or advance the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept && run.count != '0)
        begin
            count_reg <= run.count;
        end
        else if (take)
        begin
            count_reg <= count_reg - mcc_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && run.count != '0)
        begin
            chars_reg <= run.chars;
        end
        else if (take)
        begin
            chars_reg <= chars_reg >> mcc_pkg::CHAR_W;
        end
    end

endmodule

@@ rtl/morse_code_codec.sv @@
// ----------------------------------------------------------------------------
// morse_code_codec
// Streaming Morse codec for the letters A to Z, encode or decode by register.
// ----------------------------------------------------------------------------
// An input beat is taken whenever the run register is empty or its last beat
// leaves in the same cycle, so one run can follow the last with no gap.
// Each item gives a run on the single output port: an encoded letter a space
// and its marks (2 to 5 characters), an encoded space two spaces, a decoded
// letter one character; an item with no result gives no output beat. The run
// register in front of the output port holds each run. cfg_wdata selects
// decode mode (1) or encode mode (0); the user must write it while the block
// is idle, not enforced by the block; a mode change keeps pending decode marks.
// ----------------------------------------------------------------------------
module morse_code_codec (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    mcc_in_if.sink     in_ch,
    mcc_out_if.source  out_ch
);

    logic              accept;
    logic              free;
    mcc_pkg::mcc_run_t run;

    assign in_ch.ready = free;
    assign accept      = in_ch.valid && free;

    // Per-beat encode/decode and mark buffer
    mcc_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .accept         (accept),
        .in_char        (in_ch.in_char),
        .end_of_message (in_ch.end_of_message),
        .run            (run)
    );

    // Output run register
    mcc_serializer u_serializer (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .run    (run),
        .free   (free),
        .out_ch (out_ch)
    );

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming Morse codec. A scoreboard predicts the
// output characters of every accepted input beat in encode and decode mode and
// checks each output beat in order. Both channels idle at random except in the last phase.
// ----------------------------------------------------------------------------
module tb;
    import mcc_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 66;
    localparam int NUM_PHASES   = 6;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } morse_beat_t;

    // Predicts the codec output and checks the output beats in order
    class morse_tracker;
        bit                   decode_on;
        bit [2:0]             mark_cnt;
        bit [MAX_MARKS-1:0]   dash_mask;
        bit                   code_bad;
        morse_beat_t          pending[$];
        int unsigned          mismatches;
        int unsigned          beats_checked;
        int unsigned          letters_decoded;

        // Dots and dashes of each letter, A first
        static function string code_text(int idx);
            case (idx)
                0:       return ".-";
                1:       return "-...";
                2:       return "-.-.";
                3:       return "-..";
                4:       return ".";
                5:       return "..-.";
                6:       return "--.";
                7:       return "....";
                8:       return "..";
                9:       return ".---";
                10:      return "-.-";
                11:      return ".-..";
                12:      return "--";
                13:      return "-.";
                14:      return "---";
                15:      return ".--.";
                16:      return "--.-";
                17:      return ".-.";
                18:      return "...";
                19:      return "-";
                20:      return "..-";
                21:      return "...-";
                22:      return ".--";
                23:      return "-..-";
                24:      return "-.--";
                default: return "--..";
            endcase
        endfunction

        function void push_beat(logic [CHAR_W-1:0] c, logic last);
            morse_beat_t b;
            b.ch   = c;
            b.last = last;
            pending.push_back(b);
        endfunction

        // Look up the mark buffer, queue the letter on a match, then clear it
        function void flush_code();
            string              s;
            logic [MAX_MARKS-1:0] mask;
            if (!code_bad && mark_cnt != 0)
            begin
                for (int i = 0; i < NUM_LETTERS; i++)
                begin
                    s    = code_text(i);
                    mask = '0;
                    for (int k = 0; k < s.len(); k++)
                    begin
                        if (s[k] == CHAR_DASH)
                        begin
                            mask[k] = 1'b1;
                        end
                    end
                    if (s.len() == int'(mark_cnt) && mask == dash_mask)
                    begin
                        push_beat(CHAR_UPPER_A + CHAR_W'(i), 1'b1);
                        letters_decoded++;
                        break;
                    end
                end
            end
            mark_cnt  = '0;
            dash_mask = '0;
            code_bad  = 1'b0;
        endfunction

        // Note one accepted input beat and queue the characters it causes
        function void take_char(logic [CHAR_W-1:0] c, logic eom);
            string s;
            int    idx;
            idx = -1;
            if (!decode_on)
            begin
                if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                begin
                    idx = int'(c) - int'(CHAR_UPPER_A);
                end
                else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
                begin
                    idx = int'(c) - int'(CHAR_LOWER_A);
                end
                if (idx >= 0)
                begin
                    s = code_text(idx);
                    push_beat(CHAR_SPACE, 1'b0);
                    for (int i = 0; i < s.len(); i++)
                    begin
                        push_beat(s[i], i == s.len() - 1);
                    end
                end
                else if (c == CHAR_SPACE)
                begin
                    push_beat(CHAR_SPACE, 1'b0);
                    push_beat(CHAR_SPACE, 1'b1);
                end
                return;
            end
            // Decode: gather marks, flush on a space, flag anything else
            if (c == CHAR_SPACE)
            begin
                flush_code();
            end
            else if (c == CHAR_DOT || c == CHAR_DASH)
            begin
                if (mark_cnt < MAX_MARKS)
                begin
                    if (c == CHAR_DASH)
                    begin
                        dash_mask[mark_cnt] = 1'b1;
                    end
                    mark_cnt++;
                end
                else
                begin
                    code_bad = 1'b1;
                end
            end
            else
            begin
                code_bad = 1'b1;
            end
            if (eom)
            begin
                flush_code();
            end
        endfunction

        // Compare one output beat with the oldest expected beat
        function void match_char(logic [CHAR_W-1:0] c, logic last);
            morse_beat_t want;
            beats_checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: output beat char %h last %b with nothing expected",
                         $time, c, last);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (c !== want.ch)
            begin
                $display("%0t: out_char expected %h got %h", $time, want.ch, c);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_of_run expected %b got %b", $time, want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    mcc_in_if  in_bus ();
    mcc_out_if out_bus ();

    morse_code_codec uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_bus),
        .out_ch    (out_bus)
    );

    morse_tracker codec_model = new();

    bit          idling;
    int unsigned items_sent;
    int unsigned mode_writes;
    int unsigned quiet_cycles;
    int unsigned stall_left;

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Monitor both channels, feed the scoreboard, and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                codec_model.match_char(out_bus.out_char, out_bus.last_of_run);
            end
            if (in_bus.valid && in_bus.ready)
            begin
                codec_model.take_char(in_bus.in_char, in_bus.end_of_message);
            end
            if ((out_bus.valid && out_bus.ready) || (in_bus.valid && in_bus.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: watchdog expired, %0d beats still expected",
                             $time, codec_model.pending.size());
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // Output side: hold ready low in random stall bursts while idling is on
    initial
    begin
        out_bus.ready = 1'b0;
        stall_left    = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_bus.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_bus.ready = 1'b1;
                if (idling && $urandom_range(0, 5) == 0)
                begin
                    stall_left = $urandom_range(1, 9);
                end
            end
        end
    end

    // Present one input beat and hold it until accepted; maybe idle afterward
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic eom);
        in_bus.valid          = 1'b1;
        in_bus.in_char        = c;
        in_bus.end_of_message = eom;
        @(posedge clk);
        while (!in_bus.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
        if (idling && $urandom_range(0, 5) == 0)
        begin
            in_bus.valid   = 1'b0;
            in_bus.in_char = CHAR_W'($urandom_range(0, 255));
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
    endtask

    // Drain the block, then write decode_mode while it is idle
    task automatic set_mode(input logic mode);
        in_bus.valid = 1'b0;
        while (codec_model.pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = mode;
        @(negedge clk);
        cfg_we                = 1'b0;
        codec_model.decode_on = mode;
        mode_writes++;
    endtask

    // Send a string of characters, end_of_message on the last one if asked
    task automatic send_text(input string s, input logic eom_last);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], eom_last && i == s.len() - 1);
        end
    endtask

    // Random text character for encode mode: mostly letters and spaces
    task automatic send_plain_char();
        logic [CHAR_W-1:0] c;
        int                pick;
        pick = $urandom_range(0, 19);
        if (pick < 6)
        begin
            c = CHAR_UPPER_A + CHAR_W'($urandom_range(0, 25));
        end
        else if (pick < 12)
        begin
            c = CHAR_LOWER_A + CHAR_W'($urandom_range(0, 25));
        end
        else if (pick < 15)
        begin
            c = CHAR_SPACE;
        end
        else
        begin
            c = CHAR_W'($urandom_range(0, 255));
        end
        send_char(c, $urandom_range(0, 7) == 0);
    endtask

    // Random Morse word for decode mode: mostly valid letters, some broken codes
    task automatic send_morse_word();
        logic [CHAR_W-1:0] marks[$];
        string             s;
        int                kind;
        int                n;
        int                noise_at;
        bit                eom_last;
        kind     = $urandom_range(0, 19);
        noise_at = -1;
        if (kind < 14)
        begin
            s = codec_model.code_text($urandom_range(0, 25));
            for (int i = 0; i < s.len(); i++)
            begin
                marks.push_back(s[i]);
            end
        end
        else
        begin
            // Four marks may miss the table, five or more overflow the buffer
            if (kind < 16)
            begin
                n = 4;
            end
            else if (kind < 18)
            begin
                n = $urandom_range(5, 7);
            end
            else
            begin
                n        = $urandom_range(1, 4);
                noise_at = $urandom_range(0, n - 1);
            end
            for (int i = 0; i < n; i++)
            begin
                marks.push_back($urandom_range(0, 1) ? CHAR_DASH : CHAR_DOT);
            end
        end
        eom_last = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < marks.size(); i++)
        begin
            if (i == noise_at)
            begin
                send_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
            end
            send_char(marks[i], eom_last && i == marks.size() - 1);
        end
        if (!eom_last)
        begin
            send_char(CHAR_SPACE, $urandom_range(0, 7) == 0);
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = 1'b0;
        in_bus.valid          = 1'b0;
        in_bus.in_char        = '0;
        in_bus.end_of_message = 1'b0;
        idling                = 1'b1;
        items_sent            = 0;
        mode_writes           = 0;
        quiet_cycles          = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Encode: both cases, space, byte extremes, ignored end flag, the neighbor below A
        set_mode(1'b0);
        send_text("Az ", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char("Q", 1'b1);
        send_char("@", 1'b0);

        // Decode: flush on end flag, empty flush, overflow, noise, failed lookup
        set_mode(1'b1);
        send_text("-.-", 1'b1);
        send_char(CHAR_SPACE, 1'b0);
        send_text(".....", 1'b1);
        send_char(CHAR_DOT, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(CHAR_SPACE, 1'b0);
        send_text("----", 1'b1);

        // Keep pending marks across a trip through encode mode
        send_text(".-", 1'b0);
        set_mode(1'b0);
        send_char("S", 1'b0);
        set_mode(1'b1);
        send_char(CHAR_SPACE, 1'b0);

        // Random phases alternating the mode; the last phase runs without idling
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            set_mode(phase % 2 == 0);
            idling = (phase < NUM_PHASES - 1);
            n_target_loop(phase);
        end

        // Drain and settle
        in_bus.valid = 1'b0;
        while (codec_model.pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d input beats and %0d output beats; %0d letters decoded.",
                 items_sent, codec_model.beats_checked, codec_model.letters_decoded);
        $display("decode_mode written %0d times, switching between encode and decode.",
                 mode_writes);
        if (codec_model.mismatches == 0 && codec_model.pending.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Send random words or characters until the phase has its share of beats
    task automatic n_target_loop(input int phase);
        int unsigned goal;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal)
        begin
            if (phase % 2 == 0)
            begin
                send_morse_word();
            end
            else
            begin
                send_plain_char();
            end
        end
    endtask

endmodule
